[design/wsfd_pkg.sv]
`timescale 1ns / 1ps
// shared types for the websocket frame deframer
// no dependencies

package wsfd_pkg;

	localparam int unsigned LEN_W = 64;
	localparam int unsigned KEY_W = 32;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;
	localparam logic [3:0] EXT_BYTES_16 = 4'd2;
	localparam logic [3:0] EXT_BYTES_64 = 4'd8;
	localparam logic [3:0] KEY_BYTES = 4'd4;

	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXT     = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef enum logic {
		KIND_HEADER  = 1'b0,
		KIND_PAYLOAD = 1'b1
	} kind_t;

	typedef enum logic {
		ST_OK        = 1'b0,
		ST_TRUNCATED = 1'b1
	} status_t;

	typedef struct packed {
		kind_t             kind;
		logic              fin_flag;
		logic [3:0]        frame_opcode;
		logic              mask_flag;
		logic [LEN_W-1:0]  frame_length;
		logic [7:0]        payload_byte;
		logic              frame_last;
		status_t           status;
	} res_t;

endpackage

[design/wsfd_parser.sv]
`timescale 1ns / 1ps
// frame parser: header/extension/key/payload state and one-byte step logic
// depends on wsfd_pkg

module wsfd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      byte_in,
	input  logic            end_in,
	output logic            res_valid,
	output wsfd_pkg::res_t  res
);

	wsfd_pkg::phase_t ph_q, ph_n;
	logic [3:0]                   ext_q, ext_n;
	logic [wsfd_pkg::LEN_W-1:0]   len_q, len_n;
	logic [wsfd_pkg::LEN_W-1:0]   rem_q, rem_n;
	logic [wsfd_pkg::KEY_W-1:0]   key_q, key_n;
	logic [1:0]                   idx_q, idx_n;
	logic [5:0]                   hb_q, hb_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= wsfd_pkg::PH_FIRST;
			ext_q <= '0;
			len_q <= '0;
			rem_q <= '0;
			key_q <= '0;
			idx_q <= '0;
			hb_q  <= '0;
		end else if (step) begin
			ph_q  <= ph_n;
			ext_q <= ext_n;
			len_q <= len_n;
			rem_q <= rem_n;
			key_q <= key_n;
			idx_q <= idx_n;
			hb_q  <= hb_n;
		end
	end

	always_comb begin
		logic       hdr_done;
		logic [7:0] kb;
		logic       last;
		hdr_done  = 1'b0;
		kb        = '0;
		last      = 1'b0;
		ph_n      = ph_q;
		ext_n     = ext_q;
		len_n     = len_q;
		rem_n     = rem_q;
		key_n     = key_q;
		idx_n     = idx_q;
		hb_n      = hb_q;
		res_valid = 1'b0;
		res.kind         = wsfd_pkg::KIND_HEADER;
		res.payload_byte = '0;
		res.frame_last   = 1'b0;
		res.status       = wsfd_pkg::ST_OK;

		case (ph_q)
			wsfd_pkg::PH_SECOND: begin
				hb_n = {hb_q[5:1], byte_in[7]};
				if (byte_in[6:0] == wsfd_pkg::LEN_CODE_16
						|| byte_in[6:0] == wsfd_pkg::LEN_CODE_64) begin
					len_n = '0;
					ext_n = (byte_in[6:0] == wsfd_pkg::LEN_CODE_16)
						? wsfd_pkg::EXT_BYTES_16 : wsfd_pkg::EXT_BYTES_64;
					ph_n  = wsfd_pkg::PH_EXT;
				end else begin
					len_n = {{(wsfd_pkg::LEN_W-7){1'b0}}, byte_in[6:0]};
					if (byte_in[7]) begin
						ext_n = wsfd_pkg::KEY_BYTES;
						ph_n  = wsfd_pkg::PH_KEY;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			wsfd_pkg::PH_EXT: begin
				len_n = {len_q[wsfd_pkg::LEN_W-9:0], byte_in};
				ext_n = ext_q - 4'd1;
				if (ext_n == '0) begin
					if (hb_q[0]) begin
						ext_n = wsfd_pkg::KEY_BYTES;
						ph_n  = wsfd_pkg::PH_KEY;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			wsfd_pkg::PH_KEY: begin
				key_n = {key_q[wsfd_pkg::KEY_W-9:0], byte_in};
				ext_n = ext_q - 4'd1;
				if (ext_n == '0)
					hdr_done = 1'b1;
			end
			wsfd_pkg::PH_PAYLOAD: begin
				// key byte 0 sits in the top octet of the key register
				if (hb_q[0]) begin
					case (idx_q)
						2'd0:    kb = key_q[31:24];
						2'd1:    kb = key_q[23:16];
						2'd2:    kb = key_q[15:8];
						default: kb = key_q[7:0];
					endcase
				end
				idx_n = idx_q + 2'd1;
				rem_n = rem_q - {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1};
				last  = (rem_q == {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1}) || end_in;
				res_valid        = 1'b1;
				res.kind         = wsfd_pkg::KIND_PAYLOAD;
				res.payload_byte = byte_in ^ kb;
				res.frame_last   = last;
				res.status       = (rem_n != '0 && end_in)
					? wsfd_pkg::ST_TRUNCATED : wsfd_pkg::ST_OK;
				ph_n = last ? wsfd_pkg::PH_FIRST : wsfd_pkg::PH_PAYLOAD;
			end
			default: begin
				hb_n  = {byte_in[7], byte_in[3:0], 1'b0};
				len_n = '0;
				rem_n = '0;
				key_n = '0;
				idx_n = '0;
				ext_n = '0;
				ph_n  = wsfd_pkg::PH_SECOND;
			end
		endcase

		if (hdr_done) begin
			rem_n     = len_n;
			idx_n     = '0;
			res_valid = 1'b1;
			if (len_n == '0) begin
				res.frame_last = 1'b1;
				ph_n = wsfd_pkg::PH_FIRST;
			end else if (end_in) begin
				res.frame_last = 1'b1;
				res.status     = wsfd_pkg::ST_TRUNCATED;
				ph_n = wsfd_pkg::PH_FIRST;
			end else begin
				ph_n = wsfd_pkg::PH_PAYLOAD;
			end
		end else if (ph_q != wsfd_pkg::PH_PAYLOAD && end_in) begin
			// stream ran out inside the header
			res_valid      = 1'b1;
			res.frame_last = 1'b1;
			res.status     = wsfd_pkg::ST_TRUNCATED;
			ph_n = wsfd_pkg::PH_FIRST;
		end

		res.fin_flag     = hb_n[5];
		res.frame_opcode = hb_n[4:1];
		res.mask_flag    = hb_n[0];
		res.frame_length = len_n;
	end

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == wsfd_pkg::PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with nothing left");

	a_ext_count: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == wsfd_pkg::PH_EXT |-> (ext_q != '0 && ext_q <= wsfd_pkg::EXT_BYTES_64))
		else $error("extension byte count out of range");

	a_key_count: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == wsfd_pkg::PH_KEY |-> (ext_q != '0 && ext_q <= wsfd_pkg::KEY_BYTES))
		else $error("key byte count out of range");

	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.frame_last |=> ph_q == wsfd_pkg::PH_FIRST)
		else $error("frame end did not return to first header byte");

endmodule

[design/wsfd_out_reg.sv]
`timescale 1ns / 1ps
// result holding register with valid/ready toward the consumer
// depends on wsfd_pkg

module wsfd_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  wsfd_pkg::res_t  res_in,
	input  logic            ready,
	output logic            valid,
	output logic            slot_free,
	output wsfd_pkg::res_t  res_q
);

	logic valid_q;

	assign valid     = valid_q;
	assign slot_free = !valid_q || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

[design/websocket_frame_deframer_unit.sv]
`timescale 1ns / 1ps
// top level of the websocket receive frame deframer
// depends on wsfd_pkg, wsfd_parser, wsfd_out_reg

// channel   handshake                    payload
// -------   ---------------------------  -----------------------------------------
// input     data_valid / data_ready      data_byte, stream_end
// result    result_valid / result_ready  kind, fin_flag, frame_opcode, mask_flag,
//                                        frame_length, payload_byte, frame_last, status
//
// one byte per cycle sustained while the result slot is free or being taken; an item
// lands in the input register at acceptance, and the parser step then loads its
// result, if the byte yields one, into the result register, which raises result_valid
// the parser step is a single pass: phase decode, 64-bit length shift/decrement/compare
// reset (arst_n low) returns the parser to expecting a first header byte, all state zero
// a stalled result holds the input register and the parser state; bytes keep flowing
// while the result register is free or being taken in the same cycle

module websocket_frame_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        kind,
	output logic        fin_flag,
	output logic [3:0]  frame_opcode,
	output logic        mask_flag,
	output logic [63:0] frame_length,
	output logic [7:0]  payload_byte,
	output logic        frame_last,
	output logic        status
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	logic           advance;
	logic           slot_free;
	logic           res_valid;
	wsfd_pkg::res_t res_step;
	wsfd_pkg::res_t res_out;

	// the byte in stage one steps the parser only when the result slot can take it
	assign advance    = valid_s1 && slot_free;
	assign data_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			byte_s1 <= data_byte;
			end_s1  <= stream_end;
		end
	end

	wsfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_in   (byte_s1),
		.end_in    (end_s1),
		.res_valid (res_valid),
		.res       (res_step)
	);

	wsfd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res_in    (res_step),
		.ready     (result_ready),
		.valid     (result_valid),
		.slot_free (slot_free),
		.res_q     (res_out)
	);

	// unpack the result item onto its field ports
	assign kind         = res_out.kind;
	assign fin_flag     = res_out.fin_flag;
	assign frame_opcode = res_out.frame_opcode;
	assign mask_flag    = res_out.mask_flag;
	assign frame_length = res_out.frame_length;
	assign payload_byte = res_out.payload_byte;
	assign frame_last   = res_out.frame_last;
	assign status       = res_out.status;

endmodule

[bench/tb_websocket_frame_deframer_unit.sv]
`timescale 1ns / 1ps
// self-checking bench for websocket_frame_deframer_unit: directed and random frame streams
// depends on wsfd_pkg and the deframer rtl

module tb_websocket_frame_deframer_unit;

	// one stream byte as the sender offers it
	typedef struct packed {
		logic [7:0] data;
		logic       last_avail;
	} stream_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        stream_end = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        kind;
	logic        fin_flag;
	logic [3:0]  frame_opcode;
	logic        mask_flag;
	logic [63:0] frame_length;
	logic [7:0]  payload_byte;
	logic        frame_last;
	logic        status;

	// bytes still to be offered, and results the deframer owes us, oldest first
	stream_byte_t   byte_q[$];
	wsfd_pkg::res_t expected_res_q[$];

	// handshake bookkeeping, updated at the rising edge (items_sent at the falling edge)
	logic rst_done = 1'b0;
	logic byte_taken = 1'b0;
	logic res_taken = 1'b0;
	int   results_seen = 0;
	int   items_sent = 0;
	int   mismatches = 0;

	// idle control for both sides
	int   tx_gap = 0;
	int   rx_wait = 0;
	logic tx_calm = 1'b0;
	logic rx_calm = 1'b0;
	logic long_hold = 1'b0;

	// parser state as the deframer should hold it
	wsfd_pkg::phase_t parse_phase = wsfd_pkg::PH_FIRST;
	logic [3:0]  bytes_due = '0;
	logic [63:0] len_acc = '0;
	logic [63:0] payload_left = '0;
	logic [31:0] key_word = '0;
	logic [1:0]  key_pos = '0;
	logic        hdr_fin = 1'b0;
	logic [3:0]  hdr_opcode = '0;
	logic        hdr_mask = 1'b0;

	websocket_frame_deframer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_ready   (data_ready),
		.data_byte    (data_byte),
		.stream_end   (stream_end),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.fin_flag     (fin_flag),
		.frame_opcode (frame_opcode),
		.mask_flag    (mask_flag),
		.frame_length (frame_length),
		.payload_byte (payload_byte),
		.frame_last   (frame_last),
		.status       (status)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// expected behavior
	// ------------------------------------------------------------------

	// header fields of the current frame travel with every result
	function automatic wsfd_pkg::res_t frame_result(wsfd_pkg::kind_t k, logic [7:0] pb,
			logic last, wsfd_pkg::status_t st);
		wsfd_pkg::res_t r;
		r.kind         = k;
		r.fin_flag     = hdr_fin;
		r.frame_opcode = hdr_opcode;
		r.mask_flag    = hdr_mask;
		r.frame_length = len_acc;
		r.payload_byte = pb;
		r.frame_last   = last;
		r.status       = st;
		return r;
	endfunction

	// header complete: emit the header result, then payload or back to a new frame
	function automatic bit close_header(input logic at_end, output wsfd_pkg::res_t r);
		payload_left = len_acc;
		key_pos = '0;
		if (len_acc == 64'd0) begin
			// empty frame ends on its header
			r = frame_result(wsfd_pkg::KIND_HEADER, 8'h00, 1'b1, wsfd_pkg::ST_OK);
			parse_phase = wsfd_pkg::PH_FIRST;
		end else if (at_end) begin
			// buffer ran out right as the payload was due
			r = frame_result(wsfd_pkg::KIND_HEADER, 8'h00, 1'b1, wsfd_pkg::ST_TRUNCATED);
			parse_phase = wsfd_pkg::PH_FIRST;
		end else begin
			r = frame_result(wsfd_pkg::KIND_HEADER, 8'h00, 1'b0, wsfd_pkg::ST_OK);
			parse_phase = wsfd_pkg::PH_PAYLOAD;
		end
		return 1'b1;
	endfunction

	// advance the parser by one stream byte; returns 1 when a result is due
	function automatic bit deframe_byte(input logic [7:0] b, input logic at_end,
			output wsfd_pkg::res_t r);
		logic [6:0] len7;
		logic [7:0] key_byte;
		r = '0;
		len7 = b[6:0];
		case (parse_phase)
			wsfd_pkg::PH_SECOND: begin
				hdr_mask = b[7];
				if (len7 == wsfd_pkg::LEN_CODE_16 || len7 == wsfd_pkg::LEN_CODE_64) begin
					// extended length follows, gathered from zero
					len_acc = '0;
					bytes_due = (len7 == wsfd_pkg::LEN_CODE_16)
						? wsfd_pkg::EXT_BYTES_16 : wsfd_pkg::EXT_BYTES_64;
					parse_phase = wsfd_pkg::PH_EXT;
				end else begin
					len_acc = {57'd0, len7};
					if (hdr_mask) begin
						bytes_due = wsfd_pkg::KEY_BYTES;
						parse_phase = wsfd_pkg::PH_KEY;
					end else begin
						return close_header(at_end, r);
					end
				end
			end
			wsfd_pkg::PH_EXT: begin
				// big-endian, top bit taken as given
				len_acc = {len_acc[55:0], b};
				bytes_due = bytes_due - 4'd1;
				if (bytes_due == 4'd0) begin
					if (hdr_mask) begin
						bytes_due = wsfd_pkg::KEY_BYTES;
						parse_phase = wsfd_pkg::PH_KEY;
					end else begin
						return close_header(at_end, r);
					end
				end
			end
			wsfd_pkg::PH_KEY: begin
				key_word = {key_word[23:0], b};
				bytes_due = bytes_due - 4'd1;
				if (bytes_due == 4'd0)
					return close_header(at_end, r);
			end
			wsfd_pkg::PH_PAYLOAD: begin
				// key bytes used in arrival order, wrapping every four payload bytes
				key_byte = hdr_mask ? key_word[8 * (3 - key_pos) +: 8] : 8'h00;
				key_pos = key_pos + 2'd1;
				payload_left = payload_left - 64'd1;
				if (payload_left == 64'd0) begin
					r = frame_result(wsfd_pkg::KIND_PAYLOAD, b ^ key_byte, 1'b1,
						wsfd_pkg::ST_OK);
					parse_phase = wsfd_pkg::PH_FIRST;
				end else if (at_end) begin
					r = frame_result(wsfd_pkg::KIND_PAYLOAD, b ^ key_byte, 1'b1,
						wsfd_pkg::ST_TRUNCATED);
					parse_phase = wsfd_pkg::PH_FIRST;
				end else begin
					r = frame_result(wsfd_pkg::KIND_PAYLOAD, b ^ key_byte, 1'b0,
						wsfd_pkg::ST_OK);
				end
				return 1'b1;
			end
			default: begin
				// first header byte wipes everything of the previous frame
				hdr_fin = b[7];
				hdr_opcode = b[3:0];
				hdr_mask = 1'b0;
				len_acc = '0;
				payload_left = '0;
				key_word = '0;
				key_pos = '0;
				bytes_due = '0;
				parse_phase = wsfd_pkg::PH_SECOND;
			end
		endcase
		// stream ran out with the header still open
		if (at_end) begin
			r = frame_result(wsfd_pkg::KIND_HEADER, 8'h00, 1'b1, wsfd_pkg::ST_TRUNCATED);
			parse_phase = wsfd_pkg::PH_FIRST;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------

	task automatic add_byte(input logic [7:0] b, input logic at_end);
		byte_q.insert(byte_q.size(), {b, at_end});
	endtask

	// one well-formed frame with random content, sometimes cut short
	task automatic add_frame();
		logic [7:0]  fb[$];
		logic [63:0] len_val;
		logic        masked;
		logic        end_last;
		int          form;
		int          n_send;
		int          cut;
		masked = 1'($urandom_range(0, 1));
		fb.insert(fb.size(), 8'($urandom_range(0, 255)));
		form = $urandom_range(0, 9);
		// mostly short payloads, a few wide lengths that get truncated
		if (form < 5)
			len_val = 64'($urandom_range(0, 12));
		else if (form < 6)
			len_val = 64'($urandom_range(0, 125));
		else if (form < 8)
			len_val = $urandom_range(0, 1) ? 64'($urandom_range(0, 40))
				: 64'($urandom_range(0, 65535));
		else
			len_val = $urandom_range(0, 1) ? 64'($urandom_range(0, 40)) : {$urandom, $urandom};
		if (form < 6) begin
			fb.insert(fb.size(), {masked, len_val[6:0]});
		end else if (form < 8) begin
			fb.insert(fb.size(), {masked, wsfd_pkg::LEN_CODE_16});
			fb.insert(fb.size(), len_val[15:8]);
			fb.insert(fb.size(), len_val[7:0]);
		end else begin
			fb.insert(fb.size(), {masked, wsfd_pkg::LEN_CODE_64});
			for (int i = 7; i >= 0; i--)
				fb.insert(fb.size(), len_val[8 * i +: 8]);
		end
		if (masked)
			repeat (4) fb.insert(fb.size(), 8'($urandom_range(0, 255)));
		n_send = (len_val > 64) ? $urandom_range(0, 30) : int'(len_val);
		repeat (n_send) fb.insert(fb.size(), 8'($urandom_range(0, 255)));
		cut = fb.size();
		end_last = 1'b0;
		if (len_val > 64) begin
			// too long to send whole, end the buffer early
			end_last = 1'b1;
		end else begin
			case ($urandom_range(0, 9))
				0: begin
					cut = $urandom_range(1, fb.size());
					end_last = 1'b1;
				end
				1: end_last = 1'b1;
				default: ;
			endcase
		end
		for (int i = 0; i < cut; i++)
			add_byte(fb[i], end_last && (i == cut - 1));
	endtask

	// random bytes, closed by a stream end so the next frame starts clean
	task automatic add_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			add_byte(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 4) == 0));
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	function automatic string res_text(wsfd_pkg::res_t r);
		return $sformatf("kind=%0d fin=%0d op=%h mask=%0d len=%h byte=%h last=%0d st=%0d",
			r.kind, r.fin_flag, r.frame_opcode, r.mask_flag, r.frame_length,
			r.payload_byte, r.frame_last, r.status);
	endfunction

	task automatic log_mismatch(input string why, input bit have_want,
			input wsfd_pkg::res_t want, input wsfd_pkg::res_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s at result %0d (t=%0t)", why, results_seen, $time);
			if (have_want)
				$display("  expected %s", res_text(want));
			$display("  actual   %s", res_text(got));
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk) begin
		wsfd_pkg::res_t nxt;
		wsfd_pkg::res_t want;
		wsfd_pkg::res_t got;
		if (data_valid && data_ready) begin
			if (deframe_byte(data_byte, stream_end, nxt))
				expected_res_q.insert(expected_res_q.size(), nxt);
		end
		byte_taken <= data_valid && data_ready;
		res_taken <= (result_valid === 1'b1) && result_ready;
		if ((result_valid === 1'b1) && result_ready) begin
			got.kind         = wsfd_pkg::kind_t'(kind);
			got.fin_flag     = fin_flag;
			got.frame_opcode = frame_opcode;
			got.mask_flag    = mask_flag;
			got.frame_length = frame_length;
			got.payload_byte = payload_byte;
			got.frame_last   = frame_last;
			got.status       = wsfd_pkg::status_t'(status);
			if (expected_res_q.size() == 0) begin
				log_mismatch("result with nothing pending", 1'b0, got, got);
			end else begin
				want = expected_res_q.pop_front();
				if (got.kind !== want.kind || got.fin_flag !== want.fin_flag
						|| got.frame_opcode !== want.frame_opcode
						|| got.mask_flag !== want.mask_flag
						|| got.frame_length !== want.frame_length
						|| got.payload_byte !== want.payload_byte
						|| got.frame_last !== want.frame_last
						|| got.status !== want.status)
					log_mismatch("result mismatch", 1'b1, want, got);
			end
			results_seen <= results_seen + 1;
		end
	end

	// ------------------------------------------------------------------
	// sender: offers queued bytes at the falling edge
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		logic         offer;
		stream_byte_t cur;
		if (rst_done) begin
			offer = data_valid;
			if (data_valid && byte_taken) begin
				offer = 1'b0;
				items_sent++;
				// switch between idling and back-to-back stretches
				if (items_sent % 40 == 0)
					tx_calm = ($urandom_range(0, 2) == 0);
			end
			if (!offer) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (byte_q.size() > 0) begin
					cur = byte_q.pop_front();
					data_byte <= cur.data;
					stream_end <= cur.last_avail;
					offer = 1'b1;
					tx_gap = tx_calm ? 0 : $urandom_range(0, 19);
				end
			end
			// single update per edge keeps back-to-back items glitch free
			data_valid <= offer;
		end
	end

	// ------------------------------------------------------------------
	// receiver: ready pattern at the falling edge
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (rst_done) begin
			if (res_taken) begin
				if (results_seen % 40 == 0)
					rx_calm = ($urandom_range(0, 2) == 0);
				rx_wait = rx_calm ? 0 : $urandom_range(0, 19);
			end
			if (long_hold) begin
				result_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// one long back-pressure stretch so the input side has to stall
	initial begin
		wait (results_seen >= 200);
		long_hold = 1'b1;
		repeat (300) @(posedge clk);
		long_hold = 1'b0;
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------

	initial begin
		int total;

		// empty frame, all fin and opcode bits set
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		// buffer ends right after the first header byte
		add_byte(8'h0F, 1'b1);
		// buffer ends on the byte that completes a non-empty header
		add_byte(8'h01, 1'b0);
		add_byte(8'h03, 1'b1);
		// masked frame, buffer ends on its final payload byte as a normal end
		add_byte(8'h82, 1'b0);
		add_byte(8'h82, 1'b0);
		add_byte(8'hA5, 1'b0);
		add_byte(8'h5A, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b1);
		// 64-bit length with the top bit set, cut inside the payload
		add_byte(8'h80, 1'b0);
		add_byte({1'b0, wsfd_pkg::LEN_CODE_64}, 1'b0);
		add_byte(8'h80, 1'b0);
		repeat (7) add_byte(8'h00, 1'b0);
		add_byte(8'h7E, 1'b0);
		add_byte(8'hC3, 1'b1);
		// mask flag with a 16-bit length of one, key all ones
		add_byte(8'h70, 1'b0);
		add_byte({1'b1, wsfd_pkg::LEN_CODE_16}, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h01, 1'b0);
		repeat (4) add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b0);

		// random part: mostly proper frames, some noise
		while (byte_q.size() < 1650) begin
			if ($urandom_range(0, 7) == 0)
				add_noise();
			else
				add_frame();
		end
		total = byte_q.size();

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk) rst_done <= 1'b1;

		wait (items_sent == total);
		wait (expected_res_q.size() == 0);
		// two-stage pipe, leave room for anything stray
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_res_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
